// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the box blur RTL
// Concurrent property wrappers with a common clock and reset gate.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bbce_pkg.sv =====
// ----------------------------------------------------------------------------
// bbce_pkg
// Shared constants, register codes and types of the box blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbce_pkg;

    localparam int BBCE_MAX_WIDTH  = 1024;
    localparam int BBCE_MAX_HEIGHT = 1024;
    localparam int BBCE_MAX_RADIUS = 3;

    localparam int PIX_W     = 8;
    localparam int CFG_DIM_W = 11;
    localparam int CFG_RAD_W = 2;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_RADIUS = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
    localparam logic [CFG_RAD_W-1:0] RST_KERNEL_RADIUS = 2'd1;

    // stream opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_RAD_W-1:0] kernel_radius;
        logic                 written;      // one-cycle pulse on a write to width, height or radius
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bbce_regs.sv =====
// ----------------------------------------------------------------------------
// bbce_regs
// APB register file: image width, image height and kernel radius.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_regs
    import bbce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [CFG_DIM_W-1:0] width_reg, width_next;
    logic [CFG_DIM_W-1:0] height_reg, height_next;
    logic [CFG_RAD_W-1:0] radius_reg, radius_next;
    logic                 written_reg, written_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        radius_next  = radius_reg;
        written_next = 1'b0;
        if (wr)
        begin
            case (idx)
                REG_IMAGE_WIDTH:
                begin
                    width_next   = pwdata[CFG_DIM_W-1:0];
                    written_next = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next  = pwdata[CFG_DIM_W-1:0];
                    written_next = 1'b1;
                end
                REG_KERNEL_RADIUS:
                begin
                    radius_next  = pwdata[CFG_RAD_W-1:0];
                    written_next = 1'b1;
                end
                default:
                begin
                    written_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            radius_reg  <= RST_KERNEL_RADIUS;
            written_reg <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            radius_reg  <= radius_next;
            written_reg <= written_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:   prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT:  prdata = APB_DW'(height_reg);
            REG_KERNEL_RADIUS: prdata = APB_DW'(radius_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.image_width   = width_reg;
    assign cfg.image_height  = height_reg;
    assign cfg.kernel_radius = radius_reg;
    // counters clear in the cycle after the write, driven by this registered pulse
    assign cfg.written       = written_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bbce_line_store.sv =====
// ----------------------------------------------------------------------------
// bbce_line_store
// Ring of recent image rows, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_line_store
    import bbce_pkg::*;
#(
    parameter int DEPTH = 8 * BBCE_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [PIX_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bbce_divider.sv =====
// ----------------------------------------------------------------------------
// bbce_divider
// Restoring divider, one quotient bit per cycle, window sum by window area.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_divider
    import bbce_pkg::*;
#(
    parameter int MAX_RADIUS = BBCE_MAX_RADIUS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  dividend,
    input  wire logic [AREA_W-1:0] divisor,
    output logic                   done,
    output logic      [PIX_W-1:0]  quotient
);

    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
    localparam int AREA_W   = $clog2(SIDE_MAX * SIDE_MAX + 1);
    localparam int CNT_W    = $clog2(PIX_W);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dsh_reg, dsh_next;
    logic [PIX_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // quotient fits in a pixel, so the top trial is divisor << (PIX_W-1)
            rem_next  = dividend;
            dsh_next  = SUM_W'(divisor) << (PIX_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(PIX_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[PIX_W-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_reg[PIX_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/box_blur_clamped_edges.sv =====
// ----------------------------------------------------------------------------
// box_blur_clamped_edges
// Streaming (2r+1)x(2r+1) mean filter with edge-replicated borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction at a time; tuser = 1 marks a
// flush transaction. Output pixel k leaves with input k + r*width + min(r,
// width-1); after the last pixel of a frame, flush transactions (or surplus
// pixels, which are dropped) release the remaining outputs, tlast marking the
// final one. A transaction that produces output first reads the window one tap
// per cycle through the single read port of the line store, then the sum goes
// through an 8-step restoring divider. A finished result waits in the output
// register while the next transaction is accepted. Any write to the width,
// height or radius register abandons the current frame. The line store needs
// no initialization after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module box_blur_clamped_edges
    import bbce_pkg::*;
#(
    parameter int MAX_WIDTH  = BBCE_MAX_WIDTH,
    parameter int MAX_HEIGHT = BBCE_MAX_HEIGHT,
    parameter int MAX_RADIUS = BBCE_MAX_RADIUS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]        s_tuser,   // [0] opcode
    // output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [7:0]        m_tdata,   // [7:0] smoothed_pixel
    output logic                   m_tlast
);

    localparam int RING     = 2 * MAX_RADIUS + 2;
    localparam int RGW      = $clog2(RING);
    localparam int DEPTH    = RING * MAX_WIDTH;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int SW       = RW + 1;
    localparam int DW       = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
    localparam int AREA_W   = $clog2(SIDE_MAX * SIDE_MAX + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_WIN    = 4'd3;
    localparam logic [3:0] ST_DRAIN  = 4'd4;
    localparam logic [3:0] ST_DIV_GO = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;

    cfg_t cfg;

    logic [3:0]              state_reg, state_next;
    logic                    op_reg, op_next;
    logic [PIX_W-1:0]        pix_reg, pix_next;
    logic [HW-1:0]           wrow_reg, wrow_next;
    logic [CW-1:0]           wcol_reg, wcol_next;
    logic [RGW-1:0]          wring_reg, wring_next;
    logic [HW-1:0]           orow_reg, orow_next;
    logic [CW-1:0]           ocol_reg, ocol_next;
    logic [RGW-1:0]          oring_reg, oring_next;
    logic [DW-1:0]           diff_reg, diff_next;
    logic [DW-1:0]           delay_reg, delay_next;
    logic [AREA_W-1:0]       area_reg, area_next;
    logic signed [SW-1:0]    dy_reg, dy_next;
    logic signed [SW-1:0]    dx_reg, dx_next;
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]        out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic [RW-1:0]           r_eff;
    logic [WW-1:0]           w_m1;
    logic [CW-1:0]           w_m1c;
    logic [HW-1:0]           h_m1;
    logic signed [SW-1:0]    r_pos;
    logic [RW:0]             side;

    logic signed [HW+1:0]    ys;
    logic [HW-1:0]           ycl;
    logic signed [HW+1:0]    dprime;
    logic signed [RGW+1:0]   rs;
    logic signed [RGW+1:0]   rs_adj;
    logic [RGW-1:0]          ring_rd;
    logic signed [CW+1:0]    xs;
    logic [CW-1:0]           xcl;

    logic                    mem_we;
    logic                    rd_en;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic [PIX_W-1:0]        rdata;
    logic                    div_start;
    logic                    div_done;
    logic [PIX_W-1:0]        quotient;
    logic                    out_load;
    logic                    eof;

    bbce_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbce_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (pix_reg),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    bbce_divider #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (area_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // effective (clamped) configuration
    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.image_width);

        if (cfg.image_height == '0)
            h_eff = HW'(1);
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg.image_height);

        if (32'(cfg.kernel_radius) > 32'(MAX_RADIUS))
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(cfg.kernel_radius);
    end

    assign w_m1  = w_eff - WW'(1);
    assign w_m1c = CW'(w_m1);
    assign h_m1  = h_eff - HW'(1);
    assign r_pos = $signed({1'b0, r_eff});
    assign side  = {r_eff, 1'b1};

    // delay = r*w + min(r, w-1), area = (2r+1)^2; registered off the item path
    always_comb
    begin
        delay_next = DW'(r_eff) * DW'(w_eff)
                   + ((WW'(r_eff) < w_m1) ? DW'(r_eff) : DW'(w_m1));
        area_next  = AREA_W'(side) * AREA_W'(side);
    end

    // window tap address: clamp row and column, map row to its ring slot
    always_comb
    begin
        ys = $signed({2'b00, orow_reg}) + (HW+2)'(dy_reg);
        if (ys < 0)
            ycl = '0;
        else if (ys > $signed({2'b00, h_m1}))
            ycl = h_m1;
        else
            ycl = ys[HW-1:0];
        dprime = $signed({2'b00, ycl}) - $signed({2'b00, orow_reg});

        rs = $signed({2'b00, oring_reg}) + (RGW+2)'(dprime);
        if (rs < 0)
            rs_adj = rs + (RGW+2)'(RING);
        else if (rs >= (RGW+2)'(RING))
            rs_adj = rs - (RGW+2)'(RING);
        else
            rs_adj = rs;
        ring_rd = rs_adj[RGW-1:0];

        xs = $signed({2'b00, ocol_reg}) + (CW+2)'(dx_reg);
        if (xs < 0)
            xcl = '0;
        else if (xs > $signed({2'b00, w_m1c}))
            xcl = w_m1c;
        else
            xcl = xs[CW-1:0];
    end

    assign raddr = AW'(ring_rd) * AW'(MAX_WIDTH) + AW'(xcl);
    assign waddr = AW'(wring_reg) * AW'(MAX_WIDTH) + AW'(wcol_reg);
    assign eof   = (orow_reg == h_m1) && (ocol_reg == w_m1c);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pix_next       = pix_reg;
        wrow_next      = wrow_reg;
        wcol_next      = wcol_reg;
        wring_next     = wring_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        oring_next     = oring_reg;
        diff_next      = diff_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        acc_next       = acc_reg;
        rd_pend_next   = 1'b0;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser[0];
                    pix_next   = s_tdata;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                dy_next  = -r_pos;
                dx_next  = -r_pos;
                acc_next = '0;
                if (wrow_reg >= h_eff)
                begin
                    // frame input complete: any transaction releases one output
                    state_next = ST_WIN;
                end
                else if (op_reg == OP_FLUSH)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    diff_next = diff_reg + DW'(1);
                    if (wcol_reg == w_m1c)
                    begin
                        wcol_next  = '0;
                        wrow_next  = wrow_reg + HW'(1);
                        wring_next = (wring_reg == RGW'(RING - 1)) ? '0 : wring_reg + RGW'(1);
                    end
                    else
                    begin
                        wcol_next = wcol_reg + CW'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (diff_reg > delay_reg) ? ST_WIN : ST_IDLE;
            end
            ST_WIN:
            begin
                rd_en        = 1'b1;
                rd_pend_next = 1'b1;
                if (rd_pend_reg)
                    acc_next = acc_reg + SUM_W'(rdata);
                if (dx_reg == r_pos)
                begin
                    dx_next = -r_pos;
                    if (dy_reg == r_pos)
                        state_next = ST_DRAIN;
                    else
                        dy_next = dy_reg + SW'(1);
                end
                else
                begin
                    dx_next = dx_reg + SW'(1);
                end
            end
            ST_DRAIN:
            begin
                acc_next   = acc_reg + SUM_W'(rdata);
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    out_data_next = quotient;
                    out_last_next = eof;
                    if (eof)
                    begin
                        wrow_next  = '0;
                        wcol_next  = '0;
                        wring_next = '0;
                        orow_next  = '0;
                        ocol_next  = '0;
                        oring_next = '0;
                        diff_next  = '0;
                    end
                    else
                    begin
                        diff_next = diff_reg - DW'(1);
                        if (ocol_reg == w_m1c)
                        begin
                            ocol_next  = '0;
                            orow_next  = orow_reg + HW'(1);
                            oring_next = (oring_reg == RGW'(RING - 1)) ? '0
                                                                       : oring_reg + RGW'(1);
                        end
                        else
                        begin
                            ocol_next = ocol_reg + CW'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write abandons the frame
        if (cfg.written)
        begin
            wrow_next  = '0;
            wcol_next  = '0;
            wring_next = '0;
            orow_next  = '0;
            ocol_next  = '0;
            oring_next = '0;
            diff_next  = '0;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wrow_reg      <= '0;
            wcol_reg      <= '0;
            wring_reg     <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            oring_reg     <= '0;
            diff_reg      <= '0;
            delay_reg     <= '0;
            area_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wrow_reg      <= wrow_next;
            wcol_reg      <= wcol_next;
            wring_reg     <= wring_next;
            orow_reg      <= orow_next;
            ocol_reg      <= ocol_next;
            oring_reg     <= oring_next;
            diff_reg      <= diff_next;
            delay_reg     <= delay_next;
            area_reg      <= area_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pix_reg      <= pix_next;
        dy_reg       <= dy_next;
        dx_reg       <= dx_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted a transaction without going busy")
    `ASSERT_NEXT(a_eof_clears, clk, rst_n, out_load && eof && !cfg.written, (wrow_reg == '0) && (diff_reg == '0) && (orow_reg == '0), "frame counters not cleared after last output")
    `ASSERT_IMPLIES(a_lag_bound, clk, rst_n, state_reg == ST_IDLE, diff_reg <= delay_reg, "pending outputs exceed the pipeline delay")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Box blur testbench
// Streams frames of random gray pixels and flush transactions into the box
// blur, predicts each smoothed pixel and its end-of-frame flag from a local
// line-store model, and checks every output transaction in order. The geometry
// is reprogrammed between phases over the APB port, including the width and
// height extremes and all radii, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import bbce_pkg::*;
;

    localparam int RING_ROWS     = 2 * BBCE_MAX_RADIUS + 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int RUN_LIMIT     = 72_000_000;

    // index past the end of the register list; a write to it must do nothing
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } stream_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eof;
    } mean_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] pixel_in
    logic [0:0]        s_tuser  = '0;   // [0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [7:0]        m_tdata;         // [7:0] smoothed_pixel
    logic              m_tlast;

    // shadow of the block: configuration, line store and raster counters
    logic [CFG_DIM_W-1:0] cfg_width  = RST_IMAGE_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
    logic [CFG_RAD_W-1:0] cfg_radius = RST_KERNEL_RADIUS;
    logic [PIX_W-1:0]     line_ring [0:RING_ROWS*BBCE_MAX_WIDTH-1];
    int                   wr_row = 0, wr_col = 0, out_row = 0, out_col = 0;

    stream_item_t stream_q [$];
    mean_t        mean_q [$];
    stream_item_t next_item;
    mean_t        want;

    bit s_taken   = 1'b0;
    bit calm      = 1'b0;
    int send_gap  = 0;
    int hold_left = 0;

    int error_count = 0;
    int stim_count  = 0;
    int accepted    = 0;
    int results     = 0;
    int frames_done = 0;
    int reg_writes  = 0;

    box_blur_clamped_edges dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic int eff_width();
        if (cfg_width < 1)
            return 1;
        return (cfg_width > BBCE_MAX_WIDTH) ? BBCE_MAX_WIDTH : int'(cfg_width);
    endfunction

    function automatic int eff_height();
        if (cfg_height < 1)
            return 1;
        return (cfg_height > BBCE_MAX_HEIGHT) ? BBCE_MAX_HEIGHT : int'(cfg_height);
    endfunction

    function automatic int eff_radius();
        return (cfg_radius > BBCE_MAX_RADIUS) ? BBCE_MAX_RADIUS : int'(cfg_radius);
    endfunction

    // outputs trail the writer by r rows plus min(r, width-1) pixels
    function automatic int window_delay();
        int w;
        int r;
        w = eff_width();
        r = eff_radius();
        return r * w + ((r < w - 1) ? r : w - 1);
    endfunction

    function automatic int clamp_coord(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_raster();
        wr_row  = 0;
        wr_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic void apply_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = val[CFG_DIM_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height = val[CFG_DIM_W-1:0];
            REG_KERNEL_RADIUS: cfg_radius = val[CFG_RAD_W-1:0];
            default:           return;
        endcase
        clear_raster();
    endfunction

    function automatic void emit_window_mean();
        int          w, h, r, y, x, dy, dx;
        int unsigned sum;
        int unsigned side;
        mean_t       res;
        w    = eff_width();
        h    = eff_height();
        r    = eff_radius();
        sum  = 0;
        side = 2 * r + 1;
        for (dy = -r; dy <= r; dy++)
        begin
            y = clamp_coord(out_row + dy, h - 1);
            for (dx = -r; dx <= r; dx++)
            begin
                x = clamp_coord(out_col + dx, w - 1);
                sum += line_ring[(y % RING_ROWS) * BBCE_MAX_WIDTH + x];
            end
        end
        res.pixel = PIX_W'(sum / (side * side));
        res.eof   = (out_row == h - 1) && (out_col == w - 1);
        mean_q.push_back(res);
        if (res.eof)
            clear_raster();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic void window_mean_step(logic op, logic [PIX_W-1:0] pix);
        int w, h, n;
        w = eff_width();
        h = eff_height();
        // frame input complete: any transaction releases one pending output
        if (wr_row >= h)
        begin
            emit_window_mean();
            return;
        end
        if (op == OP_FLUSH)
            return;
        line_ring[(wr_row % RING_ROWS) * BBCE_MAX_WIDTH + wr_col] = pix;
        n = wr_row * w + wr_col;
        wr_col++;
        if (wr_col >= w)
        begin
            wr_col = 0;
            wr_row++;
        end
        if (n >= out_row * w + out_col + window_delay())
            emit_window_mean();
    endfunction

    function automatic void flag_mismatch(string what, int want_v, int got_v);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want_v, got_v, $time);
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int p;
        p = $urandom_range(0, 19);
        if (p < 3)
            return '0;
        if (p < 6)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic void queue_item(logic op, logic [PIX_W-1:0] pix);
        stream_item_t it;
        it.op    = op;
        it.pixel = pix;
        stream_q.push_back(it);
    endfunction

    // ---------------- stream driver and receiver (falling edge) ----------------
    always @(negedge clk)
    begin
        if (!s_tvalid || s_taken)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (stream_q.size() != 0)
            begin
                next_item = stream_q.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= next_item.pixel;
                s_tuser   <= next_item.op;
                send_gap  <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // ---------------- monitor (rising edge) ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
            s_taken <= 1'b0;
        else
        begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                window_mean_step(s_tuser[0], s_tdata);
                accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                results++;
                if (m_tlast === 1'b1)
                    frames_done++;
                if (mean_q.size() == 0)
                    flag_mismatch("unexpected output transaction, smoothed_pixel", -1, m_tdata);
                else
                begin
                    want = mean_q.pop_front();
                    if (m_tdata !== want.pixel)
                        flag_mismatch("smoothed_pixel", want.pixel, m_tdata);
                    if (m_tlast !== want.eof)
                        flag_mismatch("end_of_frame", want.eof, m_tlast);
                end
            end
        end
    end

    // ---------------- configuration and stimulus ----------------
    task automatic wait_idle();
        while (stream_q.size() != 0 || s_tvalid || mean_q.size() != 0)
            @(posedge clk);
        // a transaction without output may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_register(idx, val);
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx != REG_UNUSED)
        begin
            case (idx)
                REG_KERNEL_RADIUS: readback = APB_DW'(val[CFG_RAD_W-1:0]);
                default:           readback = APB_DW'(val[CFG_DIM_W-1:0]);
            endcase
            @(negedge clk);
            psel <= 1'b1;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== readback)
                flag_mismatch($sformatf("register %0d readback", idx), readback, prdata);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic set_geometry(input logic [APB_DW-1:0] w, input logic [APB_DW-1:0] h,
                                input logic [APB_DW-1:0] r);
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_IMAGE_HEIGHT, h);
        reg_write(REG_KERNEL_RADIUS, r);
    endtask

    // one frame (or part of one) in raster order; a complete frame is followed by exactly the
    // transactions that drain it, mostly flushes and some surplus pixels
    task automatic queue_frame(input bit whole);
        int area, npx, tail;
        area = eff_width() * eff_height();
        npx  = whole ? area : $urandom_range(0, area - 1);
        for (int i = 0; i < npx; i++)
        begin
            // flush while the frame is still open: ignored
            if ($urandom_range(0, 24) == 0)
                queue_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
            queue_item(OP_PIXEL, pick_pixel());
            stim_count++;
        end
        if (whole)
        begin
            tail = (window_delay() < area) ? window_delay() : area;
            repeat (tail)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_item(OP_PIXEL, pick_pixel());
                else
                    queue_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
                stim_count++;
            end
        end
    endtask

    function automatic logic [APB_DW-1:0] rand_dim(int hi);
        int                p;
        logic [APB_DW-1:0] v;
        p = $urandom_range(0, 9);
        if (p == 0)
            v = '0;
        else if (p < 7)
            v = APB_DW'($urandom_range(1, 8));
        else
            v = APB_DW'($urandom_range(1, hi));
        if ($urandom_range(0, 3) == 0)
            v |= APB_DW'($urandom) << CFG_DIM_W;
        return v;
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 4x3 frame at r=1, interrupted by a write to an unused address
        set_geometry(32'd4, 32'd3, 32'd1);
        queue_item(OP_FLUSH, 8'h00);
        queue_item(OP_PIXEL, 8'h00);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'h00);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'h00);
        wait_idle();
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'h00);
        queue_item(OP_PIXEL, 8'h00);
        queue_item(OP_PIXEL, 8'h80);
        queue_item(OP_PIXEL, 8'h7F);
        queue_item(OP_FLUSH, 8'hFF);
        queue_item(OP_FLUSH, 8'h00);
        queue_item(OP_PIXEL, 8'hAA);    // surplus pixel, dropped
        queue_item(OP_FLUSH, 8'h5A);
        queue_item(OP_PIXEL, 8'h55);
        wait_idle();

        // single-pixel frames back to back
        set_geometry(32'd1, 32'd1, 32'd0);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_PIXEL, 8'h00);
        wait_idle();

        // widest row (clamped), then tallest single-column frame at r=3
        set_geometry(32'h0000_07FF, 32'd1, 32'd0);
        queue_frame(1'b1);
        wait_idle();
        set_geometry(32'd0, 32'd1100, 32'hFFFF_FFFF);
        queue_frame(1'b1);
        wait_idle();

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            set_geometry(rand_dim(40), rand_dim(6),
                         APB_DW'($urandom_range(0, 3)) | (APB_DW'($urandom) << CFG_RAD_W));
            repeat ($urandom_range(1, 3)) queue_frame(1'b1);
            // partial frame left open; the next register write abandons it
            if ($urandom_range(0, 2) == 0)
                queue_frame(1'b0);
            wait_idle();
        end

        $display("Run covered %0d stream transactions, %0d smoothed pixels, %0d frames.",
                 accepted, results, frames_done);
        $display("%0d register writes: widths 1..1024, heights 1..1024, radii 0..3.",
                 reg_writes);
        if (error_count == 0)
            $display("box_blur_clamped_edges test passed");
        else
            $display("box_blur_clamped_edges test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout: %0d results still expected", mean_q.size());
        $display("box_blur_clamped_edges test failed");
        $finish;
    end

endmodule

`default_nettype wire
